@@ hw/rtl/fob_lmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fob_lmc_pkg
// Shared types and constants for the fob lock mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fob_lmc_pkg;

    // Saturation width of the tick counter and the stored counter width.
    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned TICK_W     = 16;
    localparam logic [TICK_W-1:0] COUNT_LIMIT =
        (COUNT_BITS >= TICK_W) ? {TICK_W{1'b1}}
                               : TICK_W'((64'd1 << COUNT_BITS) - 64'd1);

    // Configuration port geometry.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_FOB_MODE         = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FOB_ENABLE       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALERT_ENABLE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALERT_TARGET_SEL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCK_MASK        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RELOCK_DELAY     = 3'd5;

    // Fob modes; code three behaves as momentary.
    localparam logic [1:0] MODE_MOMENTARY = 2'd0;
    localparam logic [1:0] MODE_TOGGLE    = 2'd1;
    localparam logic [1:0] MODE_LATCH     = 2'd2;

    // Alert channel codes.
    localparam logic [1:0] ALERT_CH_BOTH   = 2'd0;
    localparam logic [1:0] ALERT_CH_FIRST  = 2'd1;
    localparam logic [1:0] ALERT_CH_SECOND = 2'd2;

    // Reset values of the registers.
    localparam logic [1:0]        RST_FOB_MODE     = MODE_MOMENTARY;
    localparam logic              RST_FOB_ENABLE   = 1'b0;
    localparam logic              RST_ALERT_ENABLE = 1'b1;
    localparam logic [1:0]        RST_ALERT_TARGET = 2'd3;
    localparam logic [1:0]        RST_LOCK_MASK    = 2'd1;
    localparam logic [TICK_W-1:0] RST_RELOCK_DELAY = 16'd4;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_PIN_SAMPLE = 2'd0,
        OP_TIMER_TICK = 2'd1,
        OP_TEST_REQ   = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]        fob_mode;
        logic              fob_enable;
        logic              alert_enable;
        logic [1:0]        alert_target_sel;
        logic [1:0]        lock_mask;
        logic [TICK_W-1:0] relock_delay;
    } cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       pin_level;
    } item_t;

    // Declared from the highest bit down, so that lock_cmd_valid is bit 0.
    typedef struct packed {
        logic       pressed_now;
        logic       access_enable;
        logic       access_cmd_valid;
        logic [1:0] alert_target_out;
        logic [1:0] alert_channel;
        logic       alert_valid;
        logic       lock_arm;
        logic [1:0] lock_cmd_mask;
        logic       lock_cmd_valid;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

@@ hw/rtl/fob_lmc_cfg.sv @@
// ----------------------------------------------------------------------------
// fob_lmc_cfg
// Configuration register file with a pulse that clears the toggle state.
// ----------------------------------------------------------------------------
`default_nettype none

module fob_lmc_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [fob_lmc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [fob_lmc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output fob_lmc_pkg::cfg_t                        cfg,
    output logic                                     toggle_clr
);

    fob_lmc_pkg::cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fob_mode         <= fob_lmc_pkg::RST_FOB_MODE;
            cfg_reg.fob_enable       <= fob_lmc_pkg::RST_FOB_ENABLE;
            cfg_reg.alert_enable     <= fob_lmc_pkg::RST_ALERT_ENABLE;
            cfg_reg.alert_target_sel <= fob_lmc_pkg::RST_ALERT_TARGET;
            cfg_reg.lock_mask        <= fob_lmc_pkg::RST_LOCK_MASK;
            cfg_reg.relock_delay     <= fob_lmc_pkg::RST_RELOCK_DELAY;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                fob_lmc_pkg::REG_FOB_MODE:
                    cfg_reg.fob_mode <= cfg_wr_data[1:0];
                fob_lmc_pkg::REG_FOB_ENABLE:
                    cfg_reg.fob_enable <= cfg_wr_data[0];
                fob_lmc_pkg::REG_ALERT_ENABLE:
                    cfg_reg.alert_enable <= cfg_wr_data[0];
                fob_lmc_pkg::REG_ALERT_TARGET_SEL:
                    cfg_reg.alert_target_sel <= cfg_wr_data[1:0];
                fob_lmc_pkg::REG_LOCK_MASK:
                    cfg_reg.lock_mask <= cfg_wr_data[1:0];
                fob_lmc_pkg::REG_RELOCK_DELAY:
                    cfg_reg.relock_delay <= cfg_wr_data[fob_lmc_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Any mode write other than toggle drops the toggle state.
    assign toggle_clr = cfg_wr_en && (cfg_addr == fob_lmc_pkg::REG_FOB_MODE)
                        && (cfg_wr_data[1:0] != fob_lmc_pkg::MODE_TOGGLE);
    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fob_lmc_engine.sv @@
// ----------------------------------------------------------------------------
// fob_lmc_engine
// Fob state registers and the single-pass logic that turns one item into
// one result.
// ----------------------------------------------------------------------------
`default_nettype none

module fob_lmc_engine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  fob_lmc_pkg::cfg_t         cfg,
    input  wire logic                 toggle_clr,
    input  wire logic                 step_en,
    input  fob_lmc_pkg::item_t        item,
    output fob_lmc_pkg::result_t      result
);

    logic                            prev_pressed_reg,  prev_pressed_next;
    logic                            pressed_state_reg, pressed_state_next;
    logic                            toggle_armed_reg,  toggle_armed_next;
    logic                            timer_idle_reg,    timer_idle_next;
    logic [fob_lmc_pkg::TICK_W-1:0]  tick_count_reg,    tick_count_next;

    logic       pressed;
    logic       user_trig;
    logic       user_level;
    logic       lock_do;
    logic       lock_arm_val;
    logic       lock_user;
    logic       toggle_flip;
    logic [1:0] mask;

    // Decide what the item triggers and how the state moves.
    always_comb begin
        prev_pressed_next  = prev_pressed_reg;
        pressed_state_next = pressed_state_reg;
        toggle_armed_next  = toggle_armed_reg;
        timer_idle_next    = timer_idle_reg;
        tick_count_next    = tick_count_reg;
        pressed            = ~item.pin_level;
        user_trig          = 1'b0;
        user_level         = 1'b1;
        lock_do            = 1'b0;
        lock_arm_val       = 1'b0;
        lock_user          = 1'b0;
        toggle_flip        = ~toggle_armed_reg;

        case (item.operation)
            fob_lmc_pkg::OP_PIN_SAMPLE: begin
                pressed_state_next = pressed;
                prev_pressed_next  = pressed;
                user_level         = pressed;
                if (cfg.fob_enable) begin
                    if (cfg.fob_mode == fob_lmc_pkg::MODE_LATCH) begin
                        user_trig = (pressed != prev_pressed_reg);
                    end else begin
                        user_trig = pressed && !prev_pressed_reg;
                    end
                end
            end
            fob_lmc_pkg::OP_TIMER_TICK: begin
                if (!timer_idle_reg && (tick_count_reg >= cfg.relock_delay)) begin
                    lock_do         = 1'b1;
                    lock_arm_val    = 1'b1;
                    timer_idle_next = 1'b1;
                end else if (tick_count_reg < fob_lmc_pkg::COUNT_LIMIT) begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
            fob_lmc_pkg::OP_TEST_REQ: begin
                user_trig = 1'b1;
            end
            default: ;
        endcase

        // A user action: latch follows the level, toggle flips, else unlock.
        if (user_trig) begin
            lock_do   = 1'b1;
            lock_user = 1'b1;
            if (cfg.fob_mode == fob_lmc_pkg::MODE_LATCH) begin
                lock_arm_val = user_level;
            end else if (cfg.fob_mode == fob_lmc_pkg::MODE_TOGGLE) begin
                toggle_armed_next = toggle_flip;
                lock_arm_val      = toggle_flip;
                timer_idle_next   = 1'b1;
            end else begin
                lock_arm_val    = 1'b0;
                timer_idle_next = 1'b0;
                tick_count_next = '0;
            end
        end
    end

    // Build the result fields.
    always_comb begin
        mask   = cfg.lock_mask;
        result = '0;
        if (lock_do) begin
            result.lock_cmd_valid = 1'b1;
            result.lock_cmd_mask  = mask;
            result.lock_arm       = lock_arm_val;
        end
        if (lock_do && lock_user && cfg.alert_enable) begin
            result.alert_valid      = 1'b1;
            result.alert_target_out = cfg.alert_target_sel;
            if (mask == 2'b11) begin
                result.alert_channel = fob_lmc_pkg::ALERT_CH_BOTH;
            end else if (mask[0]) begin
                result.alert_channel = fob_lmc_pkg::ALERT_CH_FIRST;
            end else begin
                result.alert_channel = fob_lmc_pkg::ALERT_CH_SECOND;
            end
        end
        if (lock_user && (cfg.fob_mode == fob_lmc_pkg::MODE_LATCH)) begin
            result.access_cmd_valid = 1'b1;
            result.access_enable    = user_level;
        end
        result.pressed_now = pressed_state_next;
    end

    // State registers advance once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pressed_reg  <= 1'b0;
            pressed_state_reg <= 1'b0;
            toggle_armed_reg  <= 1'b0;
            timer_idle_reg    <= 1'b1;
            tick_count_reg    <= '0;
        end else begin
            if (step_en) begin
                prev_pressed_reg  <= prev_pressed_next;
                pressed_state_reg <= pressed_state_next;
                timer_idle_reg    <= timer_idle_next;
                tick_count_reg    <= tick_count_next;
            end
            // A mode write that clears the toggle state wins over a step.
            if (toggle_clr) begin
                toggle_armed_reg <= 1'b0;
            end else if (step_en) begin
                toggle_armed_reg <= toggle_armed_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fob_lock_mode_controller_core.sv @@
// ----------------------------------------------------------------------------
// fob_lock_mode_controller_core
// Key-fob lock mode controller: pin samples, timer ticks and test requests
// in, one lock/alert/access result out per item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                          Content
//  s_        in         s_tvalid s_tready s_tdata      tdata[0] pin_level
//                       s_tuser                        tuser[1:0] operation
//  m_        out        m_tvalid m_tready m_tdata      result fields, see port
//  cfg_      in         cfg_wr_en cfg_addr cfg_wr_data register writes
//
//  One item per cycle sustained while m_tready is high; an accepted item
//  loads the input register and then the result register, which drives m_.
//  The fob state advances when an item moves from the input register into
//  the result register; that single pass sets the rate.
//  A stall on m_tready fills the result register and then the input
//  register; s_tready drops only when both are full.
//  Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module fob_lock_mode_controller_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input channel.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [fob_lmc_pkg::S_TDATA_W-1:0]   s_tdata,  // [0] pin_level
    input  wire logic [fob_lmc_pkg::S_TUSER_W-1:0]   s_tuser,  // [1:0] operation
    // Result channel.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] lock_cmd_valid, [2:1] lock_cmd_mask, [3] lock_arm, [4] alert_valid,
    // [6:5] alert_channel, [8:7] alert_target_out, [9] access_cmd_valid,
    // [10] access_enable, [11] pressed_now, [15:12] zero
    output logic [fob_lmc_pkg::M_TDATA_W-1:0]        m_tdata,
    // Configuration writes.
    input  wire logic                                cfg_wr_en,
    input  wire logic [fob_lmc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [fob_lmc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    fob_lmc_pkg::cfg_t     cfg;
    logic                  toggle_clr;
    logic                  in_valid_reg;
    fob_lmc_pkg::item_t    in_item_reg;
    logic                  out_valid_reg;
    fob_lmc_pkg::result_t  out_result_reg;
    fob_lmc_pkg::result_t  result;
    logic                  advance;

    fob_lmc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg),
        .toggle_clr  (toggle_clr)
    );

    // Move an item forward when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation <= s_tuser[1:0];
            in_item_reg.pin_level <= s_tdata[0];
        end
    end

    fob_lmc_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .toggle_clr (toggle_clr),
        .step_en    (advance),
        .item       (in_item_reg),
        .result     (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fob_lmc_pkg::M_TDATA_W - fob_lmc_pkg::RESULT_W){1'b0}},
                       out_result_reg};

endmodule

`default_nettype wire

@@ hw/rtl/fob_lmc_checker.sv @@
// ----------------------------------------------------------------------------
// fob_lmc_checker
// Port-level checks on the result channel of the fob lock mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

module fob_lmc_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [fob_lmc_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Without a lock command, mask and arm stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[3:1] == 3'b000))
        else $error("lock fields set without a lock command");

    // An alert only travels with a lock command, and without an alert its fields are zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4] ? m_tdata[0] : (m_tdata[8:5] == 4'b0000)))
        else $error("alert fields inconsistent with lock command");

    // An access command comes with a lock command of the same polarity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> (m_tdata[0] && (m_tdata[3] == m_tdata[10])))
        else $error("access command without matching lock command");

    // Padding bits stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] == 4'b0000))
        else $error("result padding not zero");

endmodule

bind fob_lock_mode_controller_core fob_lmc_checker u_fob_lmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
